// ----- src/indexed_insert_delete_list_core_macros.svh -----
// Assertion helpers used by the list core datapath.
`ifndef INDEXED_INSERT_DELETE_LIST_CORE_MACROS_SVH
`define INDEXED_INSERT_DELETE_LIST_CORE_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define IIDL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is low.
`define IIDL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/iidl_pkg.sv -----
package iidl_pkg;

    // default sizes
    localparam int CAPACITY_DEF   = 128;
    localparam int ELEM_WIDTH_DEF = 32;

    // field widths
    localparam int OPC_W      = 3;
    localparam int POS_W      = 8;
    localparam int VAL_W      = 32;
    localparam int CNT_OUT_W  = 8;
    localparam int LIMIT_W    = 8;
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 2;

    // stream packing
    localparam int IN_POS_LSB   = OPC_W;
    localparam int IN_VAL_LSB   = OPC_W + POS_W;
    localparam int IN_USED_W    = OPC_W + POS_W + VAL_W;
    localparam int TDATA_IN_W   = ((IN_USED_W + 7) / 8) * 8;
    localparam int OUT_USED_W   = 1 + VAL_W + CNT_OUT_W + 1 + 1;
    localparam int TDATA_OUT_W  = ((OUT_USED_W + 7) / 8) * 8;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd128;

    // register map
    localparam logic [APB_AW-1:0] ADDR_LIST_LIMIT = 2'd0;

    // opcodes
    localparam logic [OPC_W-1:0] OP_GET    = 3'd0;
    localparam logic [OPC_W-1:0] OP_SET    = 3'd1;
    localparam logic [OPC_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OPC_W-1:0] OP_DELETE = 3'd3;
    localparam logic [OPC_W-1:0] OP_CLEAR  = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic rd_pos;
        logic wr_pos;
        logic shift_init;
        logic shift_step;
        logic cap_rd;
        logic ok_set;
        logic cnt_inc;
        logic cnt_dec;
        logic cnt_clr;
        logic resp;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [OPC_W-1:0] op;
        logic             legal;
        logic             busy;
        logic             out_free;
    } t_sts;

endpackage

// ----- src/iidl_ram.sv -----
module iidl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/iidl_ctrl.sv -----
module iidl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  iidl_pkg::t_sts i_sts,
    output iidl_pkg::t_cmd o_cmd
);

    import iidl_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_CAP   = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_RESP;
                if (i_sts.legal) begin
                    o_cmd.ok_set = 1'b1;
                    unique case (i_sts.op)
                        OP_GET: begin
                            o_cmd.rd_pos = 1'b1;
                            n_state      = S_CAP;
                        end
                        OP_SET: begin
                            o_cmd.wr_pos = 1'b1;
                        end
                        OP_INSERT: begin
                            o_cmd.shift_init = 1'b1;
                            n_state          = S_SHIFT;
                        end
                        OP_DELETE: begin
                            o_cmd.rd_pos     = 1'b1;
                            o_cmd.shift_init = 1'b1;
                            n_state          = S_CAP;
                        end
                        OP_CLEAR: begin
                            o_cmd.cnt_clr = 1'b1;
                        end
                        default: begin
                            o_cmd.ok_set = 1'b0;
                        end
                    endcase
                end
            end
            S_CAP: begin
                o_cmd.cap_rd = 1'b1;
                n_state      = (i_sts.op == OP_DELETE) ? S_SHIFT : S_RESP;
            end
            S_SHIFT: begin
                if (i_sts.busy) begin
                    o_cmd.shift_step = 1'b1;
                end else begin
                    // move done: place the new value or drop the tail
                    if (i_sts.op == OP_INSERT) begin
                        o_cmd.wr_pos  = 1'b1;
                        o_cmd.cnt_inc = 1'b1;
                    end else begin
                        o_cmd.cnt_dec = 1'b1;
                    end
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.resp = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ----- src/iidl_dp.sv -----
`include "indexed_insert_delete_list_core_macros.svh"

module iidl_dp #(
    parameter int CAPACITY   = 128,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [iidl_pkg::TDATA_IN_W-1:0]  i_in_tdata,
    input  logic                             i_cfg_we,
    input  logic [iidl_pkg::LIMIT_W-1:0]     i_cfg_wdata,
    output logic [iidl_pkg::LIMIT_W-1:0]     o_limit,
    input  iidl_pkg::t_cmd                   i_cmd,
    output iidl_pkg::t_sts                   o_sts,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [iidl_pkg::TDATA_OUT_W-1:0] o_out_tdata
);

    import iidl_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = (CW > POS_W) ? CW : POS_W;

    // control
    logic [CW-1:0]      r_count;
    logic [LIMIT_W-1:0] r_limit;
    logic [CW-1:0]      r_reads_left;
    logic               r_wpend;
    logic               r_out_valid;

    // payload
    logic [OPC_W-1:0]       r_op;
    logic [POS_W-1:0]       r_pos;
    logic [ELEM_WIDTH-1:0]  r_val;
    logic                   r_ok;
    logic [VAL_W-1:0]       r_read_value;
    logic [AW-1:0]          r_rp;
    logic [AW-1:0]          r_wa;
    logic [TDATA_OUT_W-1:0] r_out_tdata;

    logic [LW-1:0]         cnt_w;
    logic [LW-1:0]         pos_w;
    logic [LW-1:0]         lim_w;
    logic [LW-1:0]         eff_w;
    logic [LW-1:0]         rp_ext;
    logic [LW-1:0]         rl_ext;
    logic [AW-1:0]         pos_a;
    logic [63:0]           wv64;
    logic [63:0]           rd64;
    logic                  shift_up;
    logic                  do_read;
    logic                  is_empty;
    logic                  is_full;
    logic                  legal;
    logic [TDATA_OUT_W-1:0] n_out_tdata;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [ELEM_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [ELEM_WIDTH-1:0] ram_rdata;

    assign cnt_w    = LW'(r_count);
    assign pos_w    = LW'(r_pos);
    assign lim_w    = LW'(r_limit);
    assign pos_a    = pos_w[AW-1:0];
    assign shift_up = (r_op == OP_INSERT);
    assign do_read  = i_cmd.shift_step && (r_reads_left != '0);
    assign wv64     = 64'(i_in_tdata[IN_VAL_LSB +: VAL_W]);
    assign rd64     = 64'(ram_rdata);

    // limit clamped into 1..CAPACITY
    always_comb begin
        eff_w = lim_w;
        if (lim_w == '0) begin
            eff_w = LW'(1);
        end else if (lim_w > LW'(CAPACITY)) begin
            eff_w = LW'(CAPACITY);
        end
    end

    always_comb begin
        unique case (r_op)
            OP_GET, OP_SET, OP_DELETE: legal = (pos_w < cnt_w);
            OP_INSERT:                 legal = (cnt_w < eff_w) && (pos_w <= cnt_w);
            OP_CLEAR:                  legal = 1'b1;
            default:                   legal = 1'b0;
        endcase
    end

    // shift setup: insert walks down from the tail, delete walks up from pos+1
    always_comb begin
        if (shift_up) begin
            rp_ext = cnt_w - LW'(1);
            rl_ext = cnt_w - pos_w;
        end else begin
            rp_ext = pos_w + LW'(1);
            rl_ext = cnt_w - pos_w - LW'(1);
        end
    end

    assign is_empty = (r_count == '0);
    assign is_full  = (cnt_w >= eff_w);

    assign n_out_tdata = {{(TDATA_OUT_W - OUT_USED_W){1'b0}}, is_full, is_empty,
                          cnt_w[CNT_OUT_W-1:0], r_read_value, r_ok};

    // one read and one write port; shift reads one slot, writes the one read before
    assign ram_re    = i_cmd.rd_pos || do_read;
    assign ram_raddr = i_cmd.rd_pos ? pos_a : r_rp;
    assign ram_we    = i_cmd.wr_pos || (i_cmd.shift_step && r_wpend);
    assign ram_waddr = i_cmd.wr_pos ? pos_a : r_wa;
    assign ram_wdata = i_cmd.wr_pos ? r_val : ram_rdata;

    iidl_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_limit      <= LIMIT_RESET;
            r_reads_left <= '0;
            r_wpend      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            priority if (i_cmd.cnt_clr) begin
                r_count <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - 1'b1;
            end else begin
                r_count <= r_count;
            end
            if (i_cmd.shift_init) begin
                r_reads_left <= rl_ext[CW-1:0];
                r_wpend      <= 1'b0;
            end else if (i_cmd.shift_step) begin
                r_wpend <= do_read;
                if (do_read) begin
                    r_reads_left <= r_reads_left - 1'b1;
                end
            end
            if (i_cmd.resp) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op         <= i_in_tdata[OPC_W-1:0];
            r_pos        <= i_in_tdata[IN_POS_LSB +: POS_W];
            r_val        <= wv64[ELEM_WIDTH-1:0];
            r_ok         <= 1'b0;
            r_read_value <= '0;
        end
        if (i_cmd.ok_set) begin
            r_ok <= 1'b1;
        end
        if (i_cmd.cap_rd) begin
            r_read_value <= rd64[VAL_W-1:0];
        end
        if (i_cmd.shift_init) begin
            r_rp <= rp_ext[AW-1:0];
        end else if (do_read) begin
            r_rp <= shift_up ? (r_rp - 1'b1) : (r_rp + 1'b1);
            r_wa <= shift_up ? (r_rp + 1'b1) : (r_rp - 1'b1);
        end
        if (i_cmd.resp) begin
            r_out_tdata <= n_out_tdata;
        end
    end

    assign o_limit       = r_limit;
    assign o_sts.op      = r_op;
    assign o_sts.legal   = legal;
    assign o_sts.busy    = (r_reads_left != '0) || r_wpend;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid   = r_out_valid;
    assign o_out_tdata   = r_out_tdata;

    `IIDL_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, (cnt_w <= LW'(CAPACITY)), "count above capacity")
    `IIDL_ASSERT_NXT(a_cnt_hold, i_clk, i_rst_n, !(i_cmd.cnt_inc || i_cmd.cnt_dec || i_cmd.cnt_clr), $stable(r_count), "count moved without command")
    `IIDL_ASSERT_IMP(a_wr_clash, i_clk, i_rst_n, i_cmd.wr_pos, !r_wpend, "store write collides with shift write")
    `IIDL_ASSERT_IMP(a_resp_free, i_clk, i_rst_n, i_cmd.resp, (!r_out_valid || i_out_ready), "result overwrites unsent beat")
    `IIDL_ASSERT_IMP(a_step_busy, i_clk, i_rst_n, i_cmd.shift_step, ((r_reads_left != '0) || r_wpend), "shift step while idle")

endmodule

// ----- src/indexed_insert_delete_list_core.sv -----
// Requests are handled one at a time: get reads the store, insert moves count - position
// elements up before it writes the new value, delete reads the element at position and
// then moves count - position - 1 elements down. The shift loop moves one element per cycle
// through the store's single read and single write port; a new beat is taken in the cycle
// after the previous result is registered. Synchronous active-low reset empties the list
// and sets list_limit to 128; element storage is not cleared.
module indexed_insert_delete_list_core #(
    parameter int CAPACITY   = iidl_pkg::CAPACITY_DEF,
    parameter int ELEM_WIDTH = iidl_pkg::ELEM_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request: [2:0] opcode, [10:3] position, [42:11] write_value, rest zero
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [iidl_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
    // result: [0] ok, [32:1] read_value, [40:33] element_count,
    // [41] is_empty, [42] is_full, rest zero
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [iidl_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
    // register port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [iidl_pkg::APB_AW-1:0]      paddr,
    input  logic [iidl_pkg::APB_DW-1:0]      pwdata,
    output logic [iidl_pkg::APB_DW-1:0]      prdata,
    output logic                             pready
);

    import iidl_pkg::*;

    t_cmd               cmd;
    t_sts               sts;
    logic               cfg_we;
    logic [LIMIT_W-1:0] limit;

    // list_limit is the only register; other addresses read zero, ignore writes
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == ADDR_LIST_LIMIT);
    assign prdata = (paddr == ADDR_LIST_LIMIT) ? APB_DW'(limit) : '0;

    // sequencer: one request at a time, steps the shift loop
    iidl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // store, count, limit, result register
    iidl_dp #(
        .CAPACITY   (CAPACITY),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_tdata  (s_axis_tdata),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (pwdata[LIMIT_W-1:0]),
        .o_limit     (limit),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_tdata (m_axis_tdata)
    );

endmodule
